// ===== rtl/gdts_pkg.sv =====
// Shared types, constants and calendar tables for the date-to-serial pipeline.
// Depends on nothing; every module of the block imports it.
package gdts_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DAYS_W  = 23;  // unmasked day count, years up to 16383
  localparam int unsigned TSEC_W  = 17;  // seconds within one day as given
  localparam int unsigned SEC_W   = 39;

  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
  localparam logic [16:0] SEC_PER_HOUR  = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN   = 17'd60;
  localparam logic [6:0]  YEARS_CENTURY = 7'd100;

  // floor(x / 100) = (x * 5243) >> 19 for x below 43690
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;
  // floor(x / 7) = (x * 9586981) >> 26 for x below 2**24
  localparam logic [23:0] DIV7_MUL     = 24'd9586981;
  localparam int unsigned DIV7_SHIFT   = 26;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic               is_leap;
    logic [YEAR_W-1:0]  next_year;
    logic [MONTH_W-1:0] next_month;
    logic [DAY_W-1:0]   next_day;
  } next_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [YEAR_W-1:0]  py;
    logic [26:0]        py_prod;
    logic [26:0]        y_prod;
    logic [DAYS_W-1:0]  py365;
    logic [TSEC_W-1:0]  tsec;
  } norm_t;

  typedef struct packed {
    logic [DAYS_W-1:0]  base;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [TSEC_W-1:0]  tsec;
    next_t              nxt;
  } cal_t;

  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [TSEC_W-1:0] tsec;
    next_t             nxt;
  } day_t;

  typedef struct packed {
    logic [21:0]      day_number;
    logic [SEC_W-1:0] seconds_total;
    logic [2:0]       weekday;
    next_t            nxt;
  } res_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic lp);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                      len = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    unique case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/gdts_norm.sv =====
// First pipeline stage: clamp the date fields and start the constant multiplies.
// Depends on gdts_pkg.
module gdts_norm (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [gdts_pkg::YEAR_W-1:0]    year_i,
  input  logic [gdts_pkg::MONTH_W-1:0]   month_i,
  input  logic [gdts_pkg::DAY_W-1:0]     day_i,
  input  logic [4:0]                     hour_i,
  input  logic [5:0]                     minute_i,
  input  logic [5:0]                     second_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output gdts_pkg::norm_t                data_o
);
  import gdts_pkg::*;

  logic              valid_q;
  norm_t             data_d, data_q;
  logic [YEAR_W-1:0] y;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    y = (year_i == '0) ? YEAR_W'(1) : year_i;
    data_d.year = y;
    if (month_i == '0) begin
      data_d.month = MONTH_JAN;
    end else if (month_i > MONTH_DEC) begin
      data_d.month = MONTH_DEC;
    end else begin
      data_d.month = month_i;
    end
    data_d.day     = (day_i == '0) ? DAY_W'(1) : day_i;
    data_d.py      = y - YEAR_W'(1);
    data_d.py_prod = {13'd0, data_d.py} * {14'd0, DIV100_MUL};
    data_d.y_prod  = {13'd0, y} * {14'd0, DIV100_MUL};
    data_d.py365   = {9'd0, data_d.py} * {14'd0, DAYS_PER_YEAR};
    data_d.tsec    = {12'd0, hour_i} * SEC_PER_HOUR + {11'd0, minute_i} * SEC_PER_MIN
                   + {11'd0, second_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/gdts_days.sv =====
// Stages two and three: whole-year day count, leap flag, following date, then
// the day number within the year. Depends on gdts_pkg.
module gdts_days (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  gdts_pkg::norm_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output gdts_pkg::day_t  data_o
);
  import gdts_pkg::*;

  logic               cal_valid_q, day_valid_q, cal_ready;
  cal_t               cal_d, cal_q;
  day_t               day_d, day_q;
  logic [7:0]         q100, qy;
  logic [YEAR_W-1:0]  ry;
  logic               lp;
  logic [DAY_W:0]     nd;

  assign cal_ready = !day_valid_q || ready_i;
  assign ready_o   = !cal_valid_q || cal_ready;

  // Gregorian leap rule and the year's day offset, via multiply-by-reciprocal.
  always_comb begin
    q100 = data_i.py_prod[DIV100_SHIFT +: 8];
    qy   = data_i.y_prod[DIV100_SHIFT +: 8];
    ry   = data_i.year - YEAR_W'({6'd0, qy} * {7'd0, YEARS_CENTURY});
    lp   = ((data_i.year[1:0] == 2'd0) && (ry != '0)) || ((ry == '0) && (qy[1:0] == 2'd0));

    cal_d.base  = data_i.py365 + DAYS_W'(data_i.py[YEAR_W-1:2]) - DAYS_W'(q100)
                + DAYS_W'(q100[7:2]);
    cal_d.month = data_i.month;
    cal_d.day   = data_i.day;
    cal_d.tsec  = data_i.tsec;

    nd = {1'b0, data_i.day} + (DAY_W+1)'(1);
    cal_d.nxt.is_leap    = lp;
    cal_d.nxt.next_year  = data_i.year;
    cal_d.nxt.next_month = data_i.month;
    cal_d.nxt.next_day   = nd[DAY_W-1:0];
    if (nd > {1'b0, month_len(data_i.month, lp)}) begin
      cal_d.nxt.next_day = DAY_W'(1);
      if (data_i.month == MONTH_DEC) begin
        cal_d.nxt.next_month = MONTH_JAN;
        cal_d.nxt.next_year  = data_i.year + YEAR_W'(1);
      end else begin
        cal_d.nxt.next_month = data_i.month + MONTH_W'(1);
      end
    end
  end

  always_comb begin
    day_d.days = cal_q.base + DAYS_W'(days_before(cal_q.month))
               + DAYS_W'(cal_q.nxt.is_leap && (cal_q.month > MONTH_FEB))
               + DAYS_W'(cal_q.day);
    day_d.tsec = cal_q.tsec;
    day_d.nxt  = cal_q.nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_valid_q <= 1'b0;
      day_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        cal_valid_q <= valid_i;
      end
      if (cal_ready) begin
        day_valid_q <= cal_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      cal_q <= cal_d;
    end
    if (cal_valid_q && cal_ready) begin
      day_q <= day_d;
    end
  end

  assign valid_o = day_valid_q;
  assign data_o  = day_q;

endmodule

// ===== rtl/gdts_scale.sv =====
// Stages four and five: scale days to seconds, reduce the day count mod 7,
// and hold the finished result. Depends on gdts_pkg.
module gdts_scale (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  gdts_pkg::day_t  data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output gdts_pkg::res_t  data_o
);
  import gdts_pkg::*;

  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [39:0]       sec_prod;
    logic [46:0]       w_prod;
    logic [TSEC_W-1:0] tsec;
    next_t             nxt;
  } prod_t;

  logic              prod_valid_q, res_valid_q, prod_ready;
  prod_t             prod_d, prod_q;
  res_t              res_d, res_q;
  logic [DAYS_W-1:0] dm1;
  logic [2:0]        q7_lo, w;

  assign prod_ready = !res_valid_q || ready_i;
  assign ready_o    = !prod_valid_q || prod_ready;

  always_comb begin
    dm1             = data_i.days - DAYS_W'(1);
    prod_d.days     = data_i.days;
    prod_d.sec_prod = {17'd0, dm1} * {23'd0, SEC_PER_DAY};
    prod_d.w_prod   = {24'd0, data_i.days} * {23'd0, DIV7_MUL};
    prod_d.tsec     = data_i.tsec;
    prod_d.nxt      = data_i.nxt;
  end

  // days - 7*q is below 7, and -7 is 1 mod 8, so the low bits of days + q suffice.
  always_comb begin
    q7_lo               = prod_q.w_prod[DIV7_SHIFT +: 3];
    w                   = prod_q.days[2:0] + q7_lo;
    res_d.weekday       = (w == 3'd0) ? 3'd7 : w;
    res_d.day_number    = prod_q.days[21:0];
    res_d.seconds_total = prod_q.sec_prod[SEC_W-1:0] + SEC_W'(prod_q.tsec);
    res_d.nxt           = prod_q.nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (ready_o) begin
        prod_valid_q <= valid_i;
      end
      if (prod_ready) begin
        res_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      prod_q <= prod_d;
    end
    if (prod_valid_q && prod_ready) begin
      res_q <= res_d;
    end
  end

  assign valid_o = res_valid_q;
  assign data_o  = res_q;

endmodule

// ===== rtl/gregorian_date_to_serial.sv =====
// Top level of the date-to-serial converter: five-stage pipeline from a
// Gregorian date and time to day number, seconds, weekday and following date.
// Depends on gdts_pkg, gdts_norm, gdts_days and gdts_scale.
//
//   channel | handshake              | payload
//   --------+------------------------+-----------------------------------------
//   in      | in_valid_i/in_ready_o  | year, month, day, hour, minute, second
//   out     | out_valid_o/out_ready_i| day_number, seconds_total, weekday,
//           |                        | is_leap, next_year, next_month, next_day
//
// One request enters per cycle while in_ready_o is high. Its result moves through
// the stages to the outputs, and leaves at an edge where out_ready_i is high. Five
// register stages: clamp and constant multiplies, year count and leap flag, month
// offset, seconds and mod-7 multiplies, final sums.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage loads when it is empty or its successor moves, so a stall on the
// output backs up stage by stage, bubbles close up, and nothing is dropped or
// repeated. in_ready_o is high whenever any stage is empty or out_ready_i is high.
module gregorian_date_to_serial (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gdts_pkg::YEAR_W-1:0]  year_i,
  input  logic [gdts_pkg::MONTH_W-1:0] month_i,
  input  logic [gdts_pkg::DAY_W-1:0]   day_i,
  input  logic [4:0]                   hour_i,
  input  logic [5:0]                   minute_i,
  input  logic [5:0]                   second_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [21:0]                  day_number_o,
  output logic [gdts_pkg::SEC_W-1:0]   seconds_total_o,
  output logic [2:0]                   weekday_o,
  output logic                         is_leap_o,
  output logic [gdts_pkg::YEAR_W-1:0]  next_year_o,
  output logic [gdts_pkg::MONTH_W-1:0] next_month_o,
  output logic [gdts_pkg::DAY_W-1:0]   next_day_o
);
  import gdts_pkg::*;

  // Handshake and payload between the three pipeline sections.
  logic  norm_valid, norm_ready;
  norm_t norm_data;
  logic  day_valid, day_ready;
  day_t  day_data;
  res_t  res_data;

  // Stage 1: clamp zero and out-of-range date fields, kick off the
  // reciprocal multiplies for /100 and the 365-day year product.
  gdts_norm u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .year_i   (year_i),
    .month_i  (month_i),
    .day_i    (day_i),
    .hour_i   (hour_i),
    .minute_i (minute_i),
    .second_i (second_i),
    .valid_o  (norm_valid),
    .ready_i  (norm_ready),
    .data_o   (norm_data)
  );

  // Stages 2 and 3: leap flag, whole-year day count, rollover to the
  // following date, then add the month table offset and the day.
  gdts_days u_days (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (norm_valid),
    .ready_o (norm_ready),
    .data_i  (norm_data),
    .valid_o (day_valid),
    .ready_i (day_ready),
    .data_o  (day_data)
  );

  // Stages 4 and 5: multiply out seconds and the mod-7 quotient, then
  // finish the sums into the output register.
  gdts_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (day_valid),
    .ready_o (day_ready),
    .data_i  (day_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (res_data)
  );

  // Unpack the result register onto the ports.
  assign day_number_o    = res_data.day_number;
  assign seconds_total_o = res_data.seconds_total;
  assign weekday_o       = res_data.weekday;
  assign is_leap_o       = res_data.nxt.is_leap;
  assign next_year_o     = res_data.nxt.next_year;
  assign next_month_o    = res_data.nxt.next_month;
  assign next_day_o      = res_data.nxt.next_day;

endmodule

// ===== rtl/gdts_checker.sv =====
// Port-level checks for the date-to-serial converter, bound to the top level.
// Depends on gdts_pkg for field widths.
module gdts_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [gdts_pkg::YEAR_W-1:0]  year_i,
  input logic [gdts_pkg::MONTH_W-1:0] month_i,
  input logic [gdts_pkg::DAY_W-1:0]   day_i,
  input logic [4:0]                   hour_i,
  input logic [5:0]                   minute_i,
  input logic [5:0]                   second_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [21:0]                  day_number_o,
  input logic [gdts_pkg::SEC_W-1:0]   seconds_total_o,
  input logic [2:0]                   weekday_o,
  input logic                         is_leap_o,
  input logic [gdts_pkg::YEAR_W-1:0]  next_year_o,
  input logic [gdts_pkg::MONTH_W-1:0] next_month_o,
  input logic [gdts_pkg::DAY_W-1:0]   next_day_o
);
  import gdts_pkg::*;

  // Hold a waiting request unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i
      && $stable({year_i, month_i, day_i, hour_i, minute_i, second_i}))
    else $error("waiting request changed");

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o
      && $stable({day_number_o, seconds_total_o, weekday_o, is_leap_o,
                  next_year_o, next_month_o, next_day_o}))
    else $error("stalled result changed");

  // An empty output stage means the whole pipeline can shift.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output stage");

  a_weekday: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> weekday_o != 3'd0)
    else $error("weekday zero");

  a_next_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> next_day_o != '0 && next_month_o != '0 && next_month_o <= MONTH_DEC)
    else $error("following date out of range");

endmodule

bind gregorian_date_to_serial gdts_checker u_gdts_checker (.*);
